### src/ple_pkg.sv
package ple_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_READ_AT   = 3'd6
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

### src/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/positional_list_engine_unit.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in one RAM with
// a registered read port. Each input word is one request (insert front, back
// or at a 1-based position, delete front, back or at a position, read at a
// position) and gives exactly one result word with status, read value and the
// new entry count. Requests are handled one at a time. A request that fails,
// or an insert or delete that moves no entries, goes straight to S_DONE; one
// that moves entries passes through S_SHIFT, where one entry is moved through
// the RAM per cycle, and an insert then writes its value in S_FILL. A read
// waits in S_RDWAIT for the registered RAM data. The next request is taken
// while the previous result still waits at the output.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[39:32]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], entry_count[37:32], zero[39:38]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_FILL   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic                 ins_r, ins_nxt;
  status_t              st_r, st_nxt;
  logic [VALUE_W-1:0]   rd_r, rd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [39:0]          out_data_r, out_data_nxt;
  logic [STAT_W-1:0]    out_user_r, out_user_nxt;

  logic                 we_c;
  logic [AW-1:0]        waddr_c;
  logic [VALUE_W-1:0]   wdata_c;
  logic [AW-1:0]        raddr_c;
  logic [VALUE_W-1:0]   rdata;

  action_t              act;
  logic [POS_W-1:0]     pos;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic                 full;
  logic                 empty;
  logic [AW-1:0]        pos_idx;
  logic [CW+CNT_W-1:0]  cnt_ext;

  ple_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  assign act     = action_t'(in_tuser);
  assign pos     = in_tdata[39:32];
  assign pos_w   = PW'(pos);
  assign cnt_w   = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_idx = AW'(pos - POS_W'(1));
  assign cnt_ext = (CW+CNT_W)'(count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ins_nxt       = ins_r;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    we_c          = 1'b0;
    waddr_c       = idx_r;
    wdata_c       = val_r;
    raddr_c       = ptr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt    = ST_DONE;
          rd_nxt    = '0;
          val_nxt   = in_tdata[31:0];
          state_nxt = S_DONE;
          case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else if (act == ACT_INS_AT &&
                           (pos_w == '0 || pos_w > cnt_w + PW'(1))) begin
                st_nxt = ST_BAD_POS;
              end else begin
                case (act)
                  ACT_INS_FRONT: idx_nxt = '0;
                  ACT_INS_BACK:  idx_nxt = AW'(count_r);
                  default:       idx_nxt = pos_idx;
                endcase
                ins_nxt = 1'b1;
                if (CW'(idx_nxt) < count_r) begin
                  raddr_c   = AW'(count_r - CW'(1));
                  ptr_nxt   = AW'(count_r);
                  state_nxt = S_SHIFT;
                end else begin
                  we_c      = 1'b1;
                  waddr_c   = idx_nxt;
                  wdata_c   = in_tdata[31:0];
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT, ACT_READ_AT: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else if ((act == ACT_DEL_AT || act == ACT_READ_AT) &&
                           (pos_w == '0 || pos_w > cnt_w)) begin
                st_nxt = ST_BAD_POS;
              end else if (act == ACT_READ_AT) begin
                raddr_c   = pos_idx;
                state_nxt = S_RDWAIT;
              end else begin
                case (act)
                  ACT_DEL_FRONT: idx_nxt = '0;
                  ACT_DEL_BACK:  idx_nxt = AW'(count_r - CW'(1));
                  default:       idx_nxt = pos_idx;
                endcase
                ins_nxt = 1'b0;
                if (CW'(idx_nxt) + CW'(1) < count_r) begin
                  raddr_c   = idx_nxt + AW'(1);
                  ptr_nxt   = idx_nxt;
                  state_nxt = S_SHIFT;
                end else begin
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        we_c    = 1'b1;
        waddr_c = ptr_r;
        wdata_c = rdata;
        if (ins_r) begin
          if (ptr_r - AW'(1) == idx_r) begin
            state_nxt = S_FILL;
          end else begin
            raddr_c = ptr_r - AW'(1) - AW'(1);
            ptr_nxt = ptr_r - AW'(1);
          end
        end else begin
          if (CW'(ptr_r) + CW'(1) == count_r - CW'(1)) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            raddr_c = ptr_r + AW'(1) + AW'(1);
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      S_FILL: begin
        we_c      = 1'b1;
        waddr_c   = idx_r;
        wdata_c   = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        rd_nxt    = rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, cnt_ext[CNT_W-1:0], rd_r};
          out_user_nxt  = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    ins_r      <= ins_nxt;
    st_r       <= st_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

### src/ple_checker.sv
module ple_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result word changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Request word accepted while another is in progress.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[37:32] == '0)
    else $error("Empty status with a nonzero entry count.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[37:32] == FULL_CNT)
    else $error("Full status with an entry count other than capacity.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata[31:0] == '0)
    else $error("Failed request returned a nonzero read value.");

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

### tb/sv/positional_list_engine_unit_test.sv
module positional_list_engine_unit_test;
  import ple_pkg::*;

  localparam int CAPACITY = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 165;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BROWSE} mix_t;

  typedef struct packed {
    logic [ACT_W-1:0]          act;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } list_request_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]          entry_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];
  list_request_t request_on_bus;

  logic signed [VALUE_W-1:0] list_store [CAPACITY];
  int list_len = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int cycles = 0;

  positional_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic list_result_t apply_request(list_request_t r);
    list_result_t res;
    int idx;
    res.status = ST_DONE;
    res.read_value = '0;
    case (r.act)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (r.act == ACT_INS_FRONT) idx = 0;
          else if (r.act == ACT_INS_BACK) idx = list_len;
          else idx = int'(r.position) - 1;
          if (idx < 0 || idx > list_len) begin
            res.status = ST_BAD_POS;
          end else begin
            for (int i = list_len; i > idx; i--) list_store[i] = list_store[i-1];
            list_store[idx] = r.value;
            list_len++;
          end
        end
      end
      ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT, ACT_READ_AT: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (r.act == ACT_DEL_FRONT) idx = 0;
          else if (r.act == ACT_DEL_BACK) idx = list_len - 1;
          else idx = int'(r.position) - 1;
          if (idx < 0 || idx >= list_len) begin
            res.status = ST_BAD_POS;
          end else if (r.act == ACT_READ_AT) begin
            res.read_value = list_store[idx];
          end else begin
            for (int i = idx; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
            list_len--;
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = CNT_W'(list_len);
    return res;
  endfunction

  function automatic list_request_t make_request(mix_t mix);
    list_request_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) begin
      r.act = ACT_UNUSED;
    end else begin
      case (mix)
        MIX_FILL: begin
          if (roll < 75) r.act = ACT_W'($urandom_range(ACT_INS_AT, ACT_INS_FRONT));
          else r.act = ACT_W'($urandom_range(ACT_READ_AT, ACT_DEL_FRONT));
        end
        MIX_DRAIN: begin
          if (roll < 75) r.act = ACT_W'($urandom_range(ACT_DEL_AT, ACT_DEL_FRONT));
          else r.act = ACT_W'($urandom_range(ACT_READ_AT, ACT_INS_FRONT));
        end
        default: begin
          if (roll < 50) r.act = ACT_READ_AT;
          else r.act = ACT_W'($urandom_range(ACT_READ_AT, ACT_INS_FRONT));
        end
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 5) r.value = 32'sh8000_0000;
    else if (roll < 10) r.value = 32'sh7FFF_FFFF;
    else if (roll < 13) r.value = '0;
    else if (roll < 16) r.value = -32'sd1;
    else r.value = $urandom;
    roll = $urandom_range(99);
    if (roll < 80) r.position = POS_W'($urandom_range(CAPACITY + 1, 1));
    else if (roll < 92) r.position = POS_W'($urandom_range(255, 0));
    else if (roll < 96) r.position = '0;
    else r.position = '1;
    return r;
  endfunction

  task automatic push_request(logic [ACT_W-1:0] act, logic signed [VALUE_W-1:0] value,
                              logic [POS_W-1:0] position);
    list_request_t r;
    r.act = act;
    r.value = value;
    r.position = position;
    pending_requests.push_back(r);
  endtask

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct = 80;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 80;
      end
      default: begin
        send_idle_pct = 15;
        recv_stall_pct = 15;
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(string field, longint expected_val, longint actual_val);
    failures++;
    $error("%s: expected %0d, got %0d", field, expected_val, actual_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_request(request_on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          request_on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {request_on_bus.position, request_on_bus.value};
          in_tuser <= request_on_bus.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          failures++;
          $error("result word arrived with nothing expected");
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tuser !== exp_res.status)
            report_mismatch("status", exp_res.status, out_tuser);
          if ($signed(out_tdata[31:0]) !== exp_res.read_value)
            report_mismatch("read_value", exp_res.read_value, $signed(out_tdata[31:0]));
          if (out_tdata[37:32] !== exp_res.entry_count)
            report_mismatch("entry_count", exp_res.entry_count, out_tdata[37:32]);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** positional_list_engine_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    mix_t mix;
    int burst;
    int made;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_pace(PACE_FREE);
    push_request(ACT_READ_AT, 0, 1);
    push_request(ACT_DEL_FRONT, 0, 1);
    push_request(ACT_DEL_BACK, 0, 1);
    push_request(ACT_DEL_AT, 0, 1);
    push_request(ACT_INS_AT, 5, 0);
    push_request(ACT_INS_AT, 5, 2);
    push_request(ACT_INS_AT, 32'sh8000_0000, 1);
    push_request(ACT_INS_FRONT, 32'sh7FFF_FFFF, 9);
    push_request(ACT_INS_BACK, -32'sd1, 0);
    push_request(ACT_INS_AT, 32'sh5A5A_A5A5, 4);
    push_request(ACT_INS_AT, 32'sh1234_5678, 2);
    push_request(ACT_READ_AT, 0, 1);
    push_request(ACT_READ_AT, 0, 2);
    push_request(ACT_READ_AT, 0, 5);
    push_request(ACT_READ_AT, 0, 0);
    push_request(ACT_READ_AT, 0, 6);
    push_request(ACT_READ_AT, 0, 255);
    push_request(ACT_UNUSED, -32'sd1, 255);
    push_request(ACT_DEL_AT, 0, 6);
    push_request(ACT_DEL_AT, 0, 3);
    push_request(ACT_DEL_FRONT, 0, 0);
    push_request(ACT_DEL_BACK, 0, 0);
    push_request(ACT_DEL_AT, 0, 2);
    push_request(ACT_READ_AT, 0, 1);
    push_request(ACT_DEL_AT, 0, 1);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_pace(pace_t'(ph % 4));
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        mix = mix_t'($urandom_range(MIX_BROWSE, MIX_FILL));
        burst = $urandom_range(45, 10);
        for (int k = 0; k < burst; k++) pending_requests.push_back(make_request(mix));
        made += burst;
      end
      wait_drained();
    end

    repeat (CAPACITY + 8) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("** positional_list_engine_unit: PASSED **");
    end else begin
      $display("** positional_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
